/* rtl/core/linear_interp_resampler_biquad_assert.svh */
// Assertion macros for the resampler core
`ifndef LINEAR_INTERP_RESAMPLER_BIQUAD_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_BIQUAD_ASSERT_SVH
`ifndef ASSERT_OFF
`define LRI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LRI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRI_ASSERT(lbl, clk, rst, prop, msg)
`define LRI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/lri_pkg.sv */
package lri_pkg;
  localparam int SW = 24;
  localparam int CW = 24;
  localparam int PW = 22;
  localparam int STW = 21;
  localparam logic [PW-1:0] ONE_Q16 = 22'd65536;
  localparam logic [PW-1:0] PHASE_RST = 22'd131072;
  localparam logic [STW-1:0] STEP_MIN = 21'd4096;
  localparam logic [STW-1:0] STEP_MAX = 21'd1048576;
  localparam logic [STW-1:0] DOWN_ABOVE = 21'd65542;
  localparam logic [STW-1:0] UP_BELOW = 21'd65530;
  localparam logic [4:0] MAX_OUT_M1 = 5'd15;

  typedef enum logic [2:0] {
    REG_STEP = 3'd0,
    REG_B0   = 3'd1,
    REG_B1   = 3'd2,
    REG_B2   = 3'd3,
    REG_A1   = 3'd4,
    REG_A2   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_PUSH  = 2'd2,
    OP_EMIT  = 2'd3
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
    logic     down;
    logic     up;
  } lane_cmd_t;

  typedef struct packed {
    logic signed [CW-1:0] b0;
    logic signed [CW-1:0] b1;
    logic signed [CW-1:0] b2;
    logic signed [CW-1:0] a1;
    logic signed [CW-1:0] a2;
  } coef_t;

  function automatic logic signed [SW-1:0] sat24(input logic signed [31:0] v);
    if (v > 32'sd8388607) return 24'sh7FFFFF;
    if (v < -32'sd8388608) return 24'sh800000;
    return v[SW-1:0];
  endfunction
endpackage

/* rtl/core/linear_interp_resampler_biquad.sv */
// Stereo linear-interpolation resampler with a per-channel biquad. One lane per
// channel runs in lockstep. A flush beat resets the phase and clears each lane. A
// push beat is accepted in idle. It then shifts the sample pair into the lanes,
// passing the input through the filter first while downsampling. Each output is
// preceded by a phase check and then formed by interpolation. With the output
// filter when upsampling, the lane's single biquad multiplier is shared as it steps
// through the five biquad terms. The result is then held until out_ready. Up to 16
// outputs follow one input. The next input is taken in the cycle after the last
// output is accepted, or after the phase check when the input yields no output.
`include "linear_interp_resampler_biquad_assert.svh"
module linear_interp_resampler_biquad #(
  parameter int CHANNELS = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic signed [23:0]  sample_left,
  input  logic signed [23:0]  sample_right,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [23:0]  out_left,
  output logic signed [23:0]  out_right,
  output logic                last_of_run
);
  import lri_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PUSH, S_CHECK, S_EMIT, S_OUT} st_t;

  st_t st;
  logic [STW-1:0] ratio_step, step;
  coef_t coef;
  logic [PW-1:0] phase, phase_adv;
  logic [4:0] n;
  logic down, up;
  lane_cmd_t cmd;
  logic [15:0] frac;
  logic signed [SW-1:0] smp [CHANNELS];
  logic signed [SW-1:0] res [CHANNELS];
  logic [CHANNELS-1:0] ldone;
  reg_idx_t widx;

  assign pready = 1'b1;
  assign widx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_step <= 21'd65536;
      coef <= '{b0: 24'sd2097152, b1: 24'sd4194304, b2: 24'sd2097152,
                a1: 24'sd4194304, a2: 24'sd2097152};
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_STEP: ratio_step <= pwdata[STW-1:0];
        REG_B0:   coef.b0 <= pwdata[CW-1:0];
        REG_B1:   coef.b1 <= pwdata[CW-1:0];
        REG_B2:   coef.b2 <= pwdata[CW-1:0];
        REG_A1:   coef.a1 <= pwdata[CW-1:0];
        REG_A2:   coef.a2 <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_STEP: prdata = {11'd0, ratio_step};
      REG_B0:   prdata = {{8{coef.b0[CW-1]}}, coef.b0};
      REG_B1:   prdata = {{8{coef.b1[CW-1]}}, coef.b1};
      REG_B2:   prdata = {{8{coef.b2[CW-1]}}, coef.b2};
      REG_A1:   prdata = {{8{coef.a1[CW-1]}}, coef.a1};
      REG_A2:   prdata = {{8{coef.a2[CW-1]}}, coef.a2};
      default:  prdata = '0;
    endcase
    step = (ratio_step < STEP_MIN) ? STEP_MIN :
           (ratio_step > STEP_MAX) ? STEP_MAX : ratio_step;
    down = step > DOWN_ABOVE;
    up = step < UP_BELOW;
    phase_adv = phase + PW'(step);
  end

  assign in_ready = (st == S_IDLE);
  assign out_valid = (st == S_OUT);

  always_ff @(posedge clk) begin
    cmd.op <= OP_NONE;
    cmd.down <= down;
    cmd.up <= up;
    if (rst) begin
      st <= S_IDLE;
      phase <= PHASE_RST;
      cmd.op <= OP_NONE;
    end else begin
      unique case (st)
        S_IDLE: if (in_valid) begin
          if (action) begin
            phase <= PHASE_RST;
            cmd.op <= OP_CLEAR;
          end else begin
            smp[0] <= sample_left;
            if (CHANNELS > 1) smp[CHANNELS-1] <= sample_right;
            cmd.op <= OP_PUSH;
            st <= S_PUSH;
          end
        end
        S_PUSH: if (ldone[0]) begin
          phase <= (phase >= ONE_Q16) ? phase - ONE_Q16 : '0;
          n <= '0;
          st <= S_CHECK;
        end
        S_CHECK: begin
          if (phase < ONE_Q16) begin
            frac <= phase[15:0];
            cmd.op <= OP_EMIT;
            st <= S_EMIT;
          end else begin
            st <= S_IDLE;
          end
        end
        S_EMIT: if (ldone[0]) begin
          out_left <= res[0];
          out_right <= (CHANNELS > 1) ? res[CHANNELS-1] : '0;
          last_of_run <= (n == MAX_OUT_M1) || (phase_adv >= ONE_Q16);
          phase <= phase_adv;
          n <= n + 5'd1;
          st <= S_OUT;
        end
        S_OUT: if (out_ready) st <= last_of_run ? S_IDLE : S_CHECK;
        default: st <= S_IDLE;
      endcase
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    lri_lane u_lane (
      .clk(clk), .rst(rst), .cmd(cmd), .sample(smp[c]), .frac(frac),
      .coef(coef), .done(ldone[c]), .result(res[c])
    );
  end

  `LRI_ASSERT(a_one_side, clk, rst, !(in_ready && out_valid), "both sides open")
  `LRI_ASSERT(a_last_idle, clk, rst, out_valid && out_ready && last_of_run |=> in_ready, "no idle after last")
  `LRI_ASSERT(a_flush_phase, clk, rst, in_valid && in_ready && action |=> phase == PHASE_RST, "flush phase")
  `LRI_ASSERT(a_lockstep, clk, rst, ldone == {CHANNELS{ldone[0]}}, "lanes out of step")
  `LRI_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> in_ready && !out_valid, "not idle after reset")
endmodule

/* rtl/core/lri_lane.sv */
module lri_lane (
  input  logic                         clk,
  input  logic                         rst,
  input  lri_pkg::lane_cmd_t           cmd,
  input  logic signed [23:0]           sample,
  input  logic [15:0]                  frac,
  input  lri_pkg::coef_t               coef,
  output logic                         done,
  output logic signed [23:0]           result
);
  import lri_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_INT1, S_INT2, S_FILT, S_FIN} st_t;

  st_t st;
  logic signed [SW-1:0] older, newer, x1, x2, y1, y2, xin;
  logic dest_push, down, up;
  logic [2:0] cnt;
  logic signed [47:0] prod;
  logic signed [51:0] acc;
  logic signed [41:0] iprod;
  logic signed [CW-1:0] mc;
  logic signed [SW-1:0] mo;
  logic prev_neg;
  logic signed [51:0] acc_r;
  logic signed [SW-1:0] y_new;
  logic signed [41:0] irnd;
  logic signed [SW-1:0] v_new;

  always_comb begin
    unique case (cnt)
      3'd0: begin mc = coef.b0; mo = xin; end
      3'd1: begin mc = coef.b1; mo = x1; end
      3'd2: begin mc = coef.b2; mo = x2; end
      3'd3: begin mc = coef.a1; mo = y1; end
      default: begin mc = coef.a2; mo = y2; end
    endcase
    prev_neg = (cnt >= 3'd4);
    acc_r = (acc + 52'sd1048576) >>> 21;
    y_new = sat24(acc_r > 52'sd8388607 ? 32'sd8388607 :
                  acc_r < -52'sd8388608 ? -32'sd8388608 : acc_r[31:0]);
    irnd = (iprod + 42'sd32768) >>> 16;
    v_new = sat24(32'(signed'(older)) + irnd[31:0]);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      st <= S_IDLE;
      older <= '0; newer <= '0; x1 <= '0; x2 <= '0; y1 <= '0; y2 <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          down <= cmd.down;
          up <= cmd.up;
          unique case (cmd.op)
            OP_CLEAR: begin
              older <= '0; newer <= '0; x1 <= '0; x2 <= '0; y1 <= '0; y2 <= '0;
            end
            OP_PUSH: begin
              if (cmd.down) begin
                xin <= sample; dest_push <= 1'b1; cnt <= '0; acc <= '0; st <= S_FILT;
              end else begin
                older <= newer; newer <= sample; done <= 1'b1;
              end
            end
            OP_EMIT: begin
              iprod <= (26'(signed'(newer)) - 26'(signed'(older))) * $signed({1'b0, frac});
              st <= S_INT1;
            end
            default: ;
          endcase
        end
        S_INT1: st <= S_INT2;
        S_INT2: begin
          if (up) begin
            xin <= v_new; dest_push <= 1'b0; cnt <= '0; acc <= '0; st <= S_FILT;
          end else begin
            if (!down) begin
              x2 <= x1; x1 <= v_new; y2 <= y1; y1 <= v_new;
            end
            result <= v_new; done <= 1'b1; st <= S_IDLE;
          end
        end
        S_FILT: begin
          if (cnt < 3'd5) prod <= mc * mo;
          if (cnt != 3'd0) acc <= prev_neg ? acc - 52'(prod) : acc + 52'(prod);
          if (cnt == 3'd5) st <= S_FIN;
          cnt <= cnt + 3'd1;
        end
        S_FIN: begin
          x2 <= x1; x1 <= xin; y2 <= y1; y1 <= y_new;
          if (dest_push) begin
            older <= newer; newer <= y_new;
          end else begin
            result <= y_new;
          end
          done <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
